// ===== rtl/dfsw_pkg.sv =====
// ----------------------------------------------------------------------------
// dfsw_pkg: shared types and codes of the depth-first finish-time walker
// Request and result layouts, command and result kind codes, and fixed widths.
// ----------------------------------------------------------------------------
package dfsw_pkg;

  localparam int unsigned VTX_W  = 5;  // vertex field width
  localparam int unsigned TIME_W = 6;  // finish time field width
  localparam int unsigned CNT_W  = 6;  // vertex_count register width
  localparam int unsigned CLK_W  = 7;  // internal time counter width

  // Command codes.
  localparam logic [1:0] CMD_ADD     = 2'd0;
  localparam logic [1:0] CMD_EXPLORE = 2'd1;
  localparam logic [1:0] CMD_WALK    = 2'd2;
  localparam logic [1:0] CMD_CLEAR   = 2'd3;

  // Result kind codes.
  localparam logic [1:0] KIND_FINISH = 2'd0;
  localparam logic [1:0] KIND_EDGE   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;
  localparam logic [1:0] KIND_DONE   = 2'd3;

  typedef struct packed {
    logic [1:0]       cmd;
    logic [VTX_W-1:0] src;
    logic [VTX_W-1:0] dst;
  } req_t;

  typedef struct packed {
    logic [1:0]        kind;
    logic [VTX_W-1:0]  vertex;
    logic [TIME_W-1:0] finish_time;
    logic              last;
  } res_t;

  // Request from the sequencer to the result buffer.
  typedef struct packed {
    logic              push;   // a vertex has finished
    logic              flush;  // the request is complete
    logic [1:0]        kind;   // kind of the closing result when nothing is pending
    logic [VTX_W-1:0]  vertex;
    logic [TIME_W-1:0] ftime;
  } res_req_t;

endpackage

// ===== rtl/dfsw_edge_ram.sv =====
// ----------------------------------------------------------------------------
// dfsw_edge_ram: edge store
// One write port with per-field enables and one registered read port, holding
// the link to the next edge of the same list and the target vertex.
// ----------------------------------------------------------------------------
module dfsw_edge_ram #(
  parameter int unsigned EDGES = 64
) (
  input  logic                                clk_i,
  input  logic                                wr_link_en_i,
  input  logic                                wr_tgt_en_i,
  input  logic [$clog2(EDGES)-1:0]            wr_addr_i,
  input  logic [$clog2(EDGES+1)-1:0]          wr_link_i,
  input  logic [dfsw_pkg::VTX_W-1:0]          wr_tgt_i,
  input  logic                                rd_en_i,
  input  logic [$clog2(EDGES)-1:0]            rd_addr_i,
  output logic [$clog2(EDGES+1)-1:0]          rd_link_o,
  output logic [dfsw_pkg::VTX_W-1:0]          rd_tgt_o
);

  localparam int unsigned EPW = $clog2(EDGES + 1);

  logic [EPW-1:0]             link_mem [EDGES];
  logic [dfsw_pkg::VTX_W-1:0] tgt_mem  [EDGES];

  always_ff @(posedge clk_i) begin
    if (wr_link_en_i) begin
      link_mem[wr_addr_i] <= wr_link_i;
    end
    if (wr_tgt_en_i) begin
      tgt_mem[wr_addr_i] <= wr_tgt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_link_o <= link_mem[rd_addr_i];
      rd_tgt_o  <= tgt_mem[rd_addr_i];
    end
  end

endmodule

// ===== rtl/dfsw_result_buf.sv =====
// ----------------------------------------------------------------------------
// dfsw_result_buf: result lookahead buffer
// Holds the latest finished vertex back by one so that the final result of a
// request can carry the last flag, and drives the registered result port.
// ----------------------------------------------------------------------------
module dfsw_result_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dfsw_pkg::res_req_t req_i,
  output logic               valid_o,
  output dfsw_pkg::res_t     result_o
);

  logic                          pend_valid_q, pend_valid_d;
  logic [dfsw_pkg::VTX_W-1:0]    pend_vtx_q, pend_vtx_d;
  logic [dfsw_pkg::TIME_W-1:0]   pend_time_q, pend_time_d;
  logic                          valid_q, valid_d;
  dfsw_pkg::res_t                res_q, res_d;

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_vtx_d   = pend_vtx_q;
    pend_time_d  = pend_time_q;
    valid_d      = 1'b0;
    res_d        = res_q;
    if (req_i.push) begin
      // A newer finish arrives, so the held one is not the last.
      if (pend_valid_q) begin
        valid_d           = 1'b1;
        res_d.kind        = dfsw_pkg::KIND_FINISH;
        res_d.vertex      = pend_vtx_q;
        res_d.finish_time = pend_time_q;
        res_d.last        = 1'b0;
      end
      pend_valid_d = 1'b1;
      pend_vtx_d   = req_i.vertex;
      pend_time_d  = req_i.ftime;
    end else if (req_i.flush) begin
      valid_d    = 1'b1;
      res_d.last = 1'b1;
      if (pend_valid_q) begin
        res_d.kind        = dfsw_pkg::KIND_FINISH;
        res_d.vertex      = pend_vtx_q;
        res_d.finish_time = pend_time_q;
      end else begin
        res_d.kind        = req_i.kind;
        res_d.vertex      = '0;
        res_d.finish_time = '0;
      end
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      valid_q      <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      valid_q      <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_vtx_q  <= pend_vtx_d;
    pend_time_q <= pend_time_d;
    res_q       <= res_d;
  end

  assign valid_o  = valid_q;
  assign result_o = res_q;

endmodule

// ===== rtl/dfs_finish_time_walker.sv =====
// ----------------------------------------------------------------------------
// dfs_finish_time_walker: depth-first search with finish times
// Directed graph store with edge lists in insertion order, and a sequencer
// that walks it depth first with an explicit stack, reporting finish times.
// ----------------------------------------------------------------------------
// Usage. A request (cmd, src, dst) is taken at a rising edge where start_i is
// high and busy_o is low; busy_o then stays high until the request has been
// worked through. Commands: append an edge, explore from src, walk every
// unvisited vertex below vertex_count, or clear the visit marks and the time.
// Results leave on result_o, each valid for exactly one cycle while
// result_valid_o is high; the receiver cannot stall them. The final result of
// every request carries last. An add yields one edge or reject result; a clear,
// and an explore or walk finishing no vertex, yield one done result. Steps. An
// add writes the edge in S_ADD and, if the source list has edges, relinks the
// old tail in S_ADD_LINK through the single write port of the edge store; a
// clear works in S_CLEAR. An explore enters its start in S_TRY (ends there if
// it is already visited), reads each edge in S_LOOP, enters any new target in
// S_EDGE and finishes vertices in S_LOOP; a walk tests each candidate in
// S_CHECK, tries it in S_TRY and closes in S_CHECK. The edge step spans S_LOOP
// and S_EDGE for the registered store read. The final result appears in the
// first cycle with busy_o low, as the result port is registered and the newest
// finish is held back one step. Reset empties every edge list, clears marks and
// time, and sets vertex_count to 32; the user writes configuration through
// cfg_we_i only while the block is idle, which the block does not enforce.
// ----------------------------------------------------------------------------
module dfs_finish_time_walker #(
  parameter int unsigned VERTICES = 32,
  parameter int unsigned EDGES    = 64
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  dfsw_pkg::req_t               req_i,
  output logic                         busy_o,
  input  logic                         cfg_we_i,
  input  logic [dfsw_pkg::CNT_W-1:0]   cfg_wdata_i,
  output logic                         result_valid_o,
  output dfsw_pkg::res_t               result_o
);

  localparam int unsigned VIW = (VERTICES > 1) ? $clog2(VERTICES) : 1; // vertex index
  localparam int unsigned EIW = (EDGES > 1) ? $clog2(EDGES) : 1;       // edge index
  localparam int unsigned EPW = $clog2(EDGES + 1);                     // edge pointer
  localparam int unsigned SDW = $clog2(VERTICES + 1);                  // stack depth
  localparam int unsigned SIW = VIW;                                   // stack index
  localparam logic [EPW-1:0] NIL = EPW'(EDGES);
  localparam logic [dfsw_pkg::CNT_W-1:0] VCNT = dfsw_pkg::CNT_W'(VERTICES);

  // Sequencer states.
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_ADD      = 3'd1;
  localparam logic [2:0] S_ADD_LINK = 3'd2;
  localparam logic [2:0] S_CLEAR    = 3'd3;
  localparam logic [2:0] S_CHECK    = 3'd4;
  localparam logic [2:0] S_TRY      = 3'd5;
  localparam logic [2:0] S_LOOP     = 3'd6;
  localparam logic [2:0] S_EDGE     = 3'd7;

  logic [2:0] state_q, state_d;

  // Request registers.
  logic [1:0]                  cmd_q, cmd_d;
  logic [dfsw_pkg::VTX_W-1:0]  src_q, src_d;
  logic [dfsw_pkg::VTX_W-1:0]  dst_q, dst_d;
  logic [dfsw_pkg::CNT_W-1:0]  cand_q, cand_d;       // candidate start vertex
  logic [dfsw_pkg::CNT_W-1:0]  vcnt_q;               // vertex_count register
  logic [dfsw_pkg::CNT_W-1:0]  walk_lim;

  // Graph and walk state.
  logic [EPW-1:0]              used_q, used_d;       // edges stored so far
  logic [EIW-1:0]              new_edge_q, new_edge_d;
  logic [EIW-1:0]              old_tail_q, old_tail_d;
  logic [VERTICES-1:0]         has_edges_q;          // list head and tail are valid
  logic [EIW-1:0]              head_q [VERTICES];
  logic [EIW-1:0]              tail_q [VERTICES];
  logic [VERTICES-1:0]         visited_q;
  logic [dfsw_pkg::CLK_W-1:0]  clock_q, clock_d;
  logic [SDW-1:0]              depth_q, depth_d;
  logic [VIW-1:0]              stk_vtx_q [VERTICES];
  logic [EPW-1:0]              stk_nxt_q [VERTICES];

  // Edge store port.
  logic                        ram_wlink_en, ram_wtgt_en, ram_rd_en;
  logic [EIW-1:0]              ram_waddr;
  logic [EPW-1:0]              ram_wlink;
  logic [EIW-1:0]              ram_raddr;
  logic [EPW-1:0]              ram_rlink;
  logic [dfsw_pkg::VTX_W-1:0]  ram_rtgt;

  // Sequencer controls.
  logic                        accept;
  logic                        add_go, clear_go, enter_go, pop_go, nxt_upd;
  logic [VIW-1:0]              enter_vtx;
  logic [dfsw_pkg::CNT_W-1:0]  enter_cand;
  logic [EPW-1:0]              enter_head;
  logic                        enter_ok;
  logic [SDW-1:0]              depth_m1;
  logic [SIW-1:0]              top_idx;
  logic [SIW-1:0]              push_idx;
  logic [VIW-1:0]              src_idx;
  logic                        add_ok;
  dfsw_pkg::res_req_t          res_req;

  assign accept   = start_i && (state_q == S_IDLE);
  assign busy_o   = (state_q != S_IDLE);
  assign walk_lim = (vcnt_q > VCNT) ? VCNT : vcnt_q;
  assign depth_m1 = depth_q - SDW'(1);
  assign top_idx  = depth_m1[SIW-1:0];
  assign push_idx = depth_q[SIW-1:0];
  assign src_idx  = src_q[VIW-1:0];

  assign add_ok = (used_q < NIL) &&
                  ({1'b0, src_q} < VCNT) && ({1'b0, dst_q} < VCNT);

  // A vertex is entered either as the explore or walk candidate or as the
  // target of the edge just read from the store; one shared lookup serves both.
  assign enter_cand = (state_q == S_EDGE) ? {1'b0, ram_rtgt} : cand_q;
  assign enter_vtx  = enter_cand[VIW-1:0];
  assign enter_head = has_edges_q[enter_vtx] ? EPW'(head_q[enter_vtx]) : NIL;
  assign enter_ok   = (enter_cand < VCNT) && !visited_q[enter_vtx] &&
                      (depth_q < SDW'(VERTICES));

  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    src_d        = src_q;
    dst_d        = dst_q;
    cand_d       = cand_q;
    used_d       = used_q;
    new_edge_d   = new_edge_q;
    old_tail_d   = old_tail_q;
    clock_d      = clock_q;
    depth_d      = depth_q;
    add_go       = 1'b0;
    clear_go     = 1'b0;
    enter_go     = 1'b0;
    pop_go       = 1'b0;
    nxt_upd      = 1'b0;
    ram_wlink_en = 1'b0;
    ram_wtgt_en  = 1'b0;
    ram_waddr    = used_q[EIW-1:0];
    ram_wlink    = NIL;
    ram_rd_en    = 1'b0;
    ram_raddr    = stk_nxt_q[top_idx][EIW-1:0];
    res_req      = '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          cmd_d = req_i.cmd;
          src_d = req_i.src;
          dst_d = req_i.dst;
          unique case (req_i.cmd)
            dfsw_pkg::CMD_ADD: begin
              state_d = S_ADD;
            end
            dfsw_pkg::CMD_EXPLORE: begin
              cand_d  = {1'b0, req_i.src};
              state_d = S_TRY;
            end
            dfsw_pkg::CMD_WALK: begin
              cand_d  = '0;
              state_d = S_CHECK;
            end
            default: begin
              state_d = S_CLEAR;
            end
          endcase
        end
      end

      S_ADD: begin
        if (!add_ok) begin
          res_req.flush = 1'b1;
          res_req.kind  = dfsw_pkg::KIND_REJECT;
          state_d       = S_IDLE;
        end else begin
          add_go       = 1'b1;
          ram_wlink_en = 1'b1;
          ram_wtgt_en  = 1'b1;
          used_d       = used_q + EPW'(1);
          new_edge_d   = used_q[EIW-1:0];
          old_tail_d   = tail_q[src_idx];
          if (has_edges_q[src_idx]) begin
            state_d = S_ADD_LINK;
          end else begin
            res_req.flush = 1'b1;
            res_req.kind  = dfsw_pkg::KIND_EDGE;
            state_d       = S_IDLE;
          end
        end
      end

      S_ADD_LINK: begin
        // Chain the new edge behind the previous tail of the list.
        ram_wlink_en  = 1'b1;
        ram_waddr     = old_tail_q;
        ram_wlink     = EPW'(new_edge_q);
        res_req.flush = 1'b1;
        res_req.kind  = dfsw_pkg::KIND_EDGE;
        state_d       = S_IDLE;
      end

      S_CLEAR: begin
        clear_go      = 1'b1;
        clock_d       = '0;
        depth_d       = '0;
        res_req.flush = 1'b1;
        res_req.kind  = dfsw_pkg::KIND_DONE;
        state_d       = S_IDLE;
      end

      S_CHECK: begin
        if (cand_q < walk_lim) begin
          state_d = S_TRY;
        end else begin
          res_req.flush = 1'b1;
          res_req.kind  = dfsw_pkg::KIND_DONE;
          state_d       = S_IDLE;
        end
      end

      S_TRY: begin
        if (enter_ok) begin
          enter_go = 1'b1;
          clock_d  = clock_q + dfsw_pkg::CLK_W'(1);
          depth_d  = depth_q + SDW'(1);
          state_d  = S_LOOP;
        end else if (cmd_q == dfsw_pkg::CMD_WALK) begin
          cand_d  = cand_q + dfsw_pkg::CNT_W'(1);
          state_d = S_CHECK;
        end else begin
          res_req.flush = 1'b1;
          res_req.kind  = dfsw_pkg::KIND_DONE;
          state_d       = S_IDLE;
        end
      end

      S_LOOP: begin
        if (depth_q == '0) begin
          // The tree rooted at the candidate is complete.
          if (cmd_q == dfsw_pkg::CMD_WALK) begin
            cand_d  = cand_q + dfsw_pkg::CNT_W'(1);
            state_d = S_CHECK;
          end else begin
            res_req.flush = 1'b1;
            res_req.kind  = dfsw_pkg::KIND_DONE;
            state_d       = S_IDLE;
          end
        end else if (stk_nxt_q[top_idx] >= NIL) begin
          // The top vertex has no edges left: it finishes now.
          pop_go         = 1'b1;
          res_req.push   = 1'b1;
          res_req.vertex = dfsw_pkg::VTX_W'(stk_vtx_q[top_idx]);
          res_req.ftime  = clock_q[dfsw_pkg::TIME_W-1:0];
          clock_d        = clock_q + dfsw_pkg::CLK_W'(1);
          depth_d        = depth_m1;
        end else begin
          ram_rd_en = 1'b1;
          state_d   = S_EDGE;
        end
      end

      S_EDGE: begin
        nxt_upd = 1'b1;
        if (enter_ok) begin
          enter_go = 1'b1;
          clock_d  = clock_q + dfsw_pkg::CLK_W'(1);
          depth_d  = depth_q + SDW'(1);
        end
        state_d = S_LOOP;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vcnt_q      <= dfsw_pkg::CNT_W'(32);
      used_q      <= '0;
      has_edges_q <= '0;
      visited_q   <= '0;
      clock_q     <= '0;
      depth_q     <= '0;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      clock_q <= clock_d;
      depth_q <= depth_d;
      if (cfg_we_i) begin
        vcnt_q <= cfg_wdata_i;
      end
      if (add_go) begin
        has_edges_q[src_idx] <= 1'b1;
      end
      if (clear_go) begin
        visited_q <= '0;
      end else if (enter_go) begin
        visited_q[enter_vtx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q      <= cmd_d;
    src_q      <= src_d;
    dst_q      <= dst_d;
    cand_q     <= cand_d;
    new_edge_q <= new_edge_d;
    old_tail_q <= old_tail_d;
    if (add_go) begin
      tail_q[src_idx] <= used_q[EIW-1:0];
      if (!has_edges_q[src_idx]) begin
        head_q[src_idx] <= used_q[EIW-1:0];
      end
    end
    if (nxt_upd) begin
      stk_nxt_q[top_idx] <= ram_rlink;
    end
    if (enter_go) begin
      stk_vtx_q[push_idx] <= enter_vtx;
      stk_nxt_q[push_idx] <= enter_head;
    end
  end

  dfsw_edge_ram #(
    .EDGES (EDGES)
  ) u_edge_ram (
    .clk_i        (clk_i),
    .wr_link_en_i (ram_wlink_en),
    .wr_tgt_en_i  (ram_wtgt_en),
    .wr_addr_i    (ram_waddr),
    .wr_link_i    (ram_wlink),
    .wr_tgt_i     (dst_q),
    .rd_en_i      (ram_rd_en),
    .rd_addr_i    (ram_raddr),
    .rd_link_o    (ram_rlink),
    .rd_tgt_o     (ram_rtgt)
  );

  dfsw_result_buf u_result_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (res_req),
    .valid_o  (result_valid_o),
    .result_o (result_o)
  );

endmodule

// ===== rtl/dfsw_checker.sv =====
// ----------------------------------------------------------------------------
// dfsw_checker: port-level checks of the depth-first finish-time walker
// Watches the request, busy and result ports; attached to the top by bind.
// ----------------------------------------------------------------------------
module dfsw_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               start_i,
  input logic               busy_o,
  input logic               result_valid_o,
  input dfsw_pkg::res_t     result_o
);

  // Every accepted request leaves the block busy in the following cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> busy_o)
    else $error("request accepted but block not busy");

  // The closing result of a request only appears once the block is idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && result_o.last |-> !busy_o)
    else $error("final result while still busy");

  // Results that are not the last belong to an explore or walk still in progress.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> busy_o)
    else $error("intermediate result while idle");

  // Only finished vertices can be followed by further results.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.last |-> result_o.kind == dfsw_pkg::KIND_FINISH)
    else $error("non-finish result without last");

endmodule

bind dfs_finish_time_walker dfsw_checker u_dfsw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);

// ===== sim/dfs_finish_time_walker_checker.sv =====
// ----------------------------------------------------------------------------
// dfs_finish_time_walker_checker: result checker for the finish-time walker
// Watches the request, configuration and result channels, keeps its own copy
// of the graph, the visit marks and the time, and compares each result with
// the oldest one it has worked out.
// ----------------------------------------------------------------------------
module dfs_finish_time_walker_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic                          busy_i,
  input  dfsw_pkg::req_t                req_i,
  input  logic                          cfg_we_i,
  input  logic [dfsw_pkg::CNT_W-1:0]    cfg_wdata_i,
  input  logic                          result_valid_i,
  input  dfsw_pkg::res_t                result_i,
  output int                            mismatch_count_o,
  output int                            outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int         VERTS     = 32;
  localparam int         EDGE_CAP  = 64;
  localparam logic [6:0] NULL_EDGE = 7'd64;

  // Graph store, visit state and the walk stack.
  logic [6:0]                 head_q   [VERTS];
  logic [6:0]                 tail_q   [VERTS];
  logic [6:0]                 link_q   [EDGE_CAP];
  logic [dfsw_pkg::VTX_W-1:0] target_q [EDGE_CAP];
  logic [6:0]                 used_q;
  logic                       visited_q[VERTS];
  logic [dfsw_pkg::CLK_W-1:0] time_q;
  logic [dfsw_pkg::VTX_W-1:0] frame_vtx [VERTS];
  logic [6:0]                 frame_next[VERTS];
  int                         depth;
  logic [dfsw_pkg::CNT_W-1:0] vcount_q;

  dfsw_pkg::res_t due_results[$];
  int             finishes_made;

  task automatic clear_graph();
    int i;
    for (i = 0; i < VERTS; i++) begin
      head_q[i]    = NULL_EDGE;
      tail_q[i]    = NULL_EDGE;
      visited_q[i] = 1'b0;
    end
    used_q   = '0;
    time_q   = '0;
    depth    = 0;
    vcount_q = 6'd32;
    due_results.delete();
    mismatch_count_o = 0;
  endtask

  task automatic queue_result(input logic [1:0] kind, input int v, input int t);
    dfsw_pkg::res_t r;
    r.kind        = kind;
    r.vertex      = dfsw_pkg::VTX_W'(v);
    r.finish_time = dfsw_pkg::TIME_W'(t);
    r.last        = 1'b0;
    due_results.push_back(r);
    finishes_made++;
  endtask

  task automatic enter_vertex(input int v);
    time_q            = time_q + 1'b1;
    visited_q[v]      = 1'b1;
    frame_vtx[depth]  = dfsw_pkg::VTX_W'(v);
    frame_next[depth] = head_q[v];
    depth++;
  endtask

  task automatic explore_from(input int v);
    int         tos;
    logic [6:0] e;
    int         w;
    if (visited_q[v] || depth >= VERTS) return;
    enter_vertex(v);
    while (depth > 0) begin
      tos = depth - 1;
      if (frame_next[tos] >= NULL_EDGE) begin
        queue_result(dfsw_pkg::KIND_FINISH, int'(frame_vtx[tos]), int'(time_q));
        time_q = time_q + 1'b1;
        depth--;
      end else begin
        e               = frame_next[tos];
        w               = int'(target_q[e[5:0]]);
        frame_next[tos] = link_q[e[5:0]];
        if (!visited_q[w] && depth < VERTS) enter_vertex(w);
      end
    end
  endtask

  task automatic run_request(input dfsw_pkg::req_t r);
    int lim;
    int v;
    finishes_made = 0;
    case (r.cmd)
      dfsw_pkg::CMD_ADD: begin
        if (used_q >= EDGE_CAP) begin
          queue_result(dfsw_pkg::KIND_REJECT, 0, 0);
        end else begin
          target_q[used_q[5:0]] = r.dst;
          link_q[used_q[5:0]]   = NULL_EDGE;
          if (head_q[r.src] >= NULL_EDGE) head_q[r.src] = used_q;
          else link_q[tail_q[r.src][5:0]] = used_q;
          tail_q[r.src] = used_q;
          used_q        = used_q + 1'b1;
          queue_result(dfsw_pkg::KIND_EDGE, 0, 0);
        end
      end
      dfsw_pkg::CMD_EXPLORE: explore_from(int'(r.src));
      dfsw_pkg::CMD_WALK: begin
        lim = (vcount_q > VERTS) ? VERTS : int'(vcount_q);
        for (v = 0; v < lim; v++) explore_from(v);
      end
      default: begin
        for (v = 0; v < VERTS; v++) visited_q[v] = 1'b0;
        time_q = '0;
        depth  = 0;
        queue_result(dfsw_pkg::KIND_DONE, 0, 0);
      end
    endcase
    // A request that finished nothing still closes with one done result.
    if (finishes_made == 0) queue_result(dfsw_pkg::KIND_DONE, 0, 0);
    due_results[due_results.size() - 1].last = 1'b1;
  endtask

  task automatic check_result(input dfsw_pkg::res_t got);
    dfsw_pkg::res_t want;
    if (due_results.size() == 0) begin
      if (mismatch_count_o < 10)
        $display("%0t: result with nothing expected: kind %0d vertex %0d %s %0d %0b",
                 $time, got.kind, got.vertex, "time/last", got.finish_time, got.last);
      mismatch_count_o++;
    end else begin
      want = due_results.pop_front();
      if (got.kind !== want.kind || got.vertex !== want.vertex ||
          got.finish_time !== want.finish_time || got.last !== want.last) begin
        if (mismatch_count_o < 10)
          $display({"%0t: mismatch: expected kind %0d vertex %0d time %0d last %0b,",
                    " got kind %0d vertex %0d time %0d last %0b"},
                   $time, want.kind, want.vertex, want.finish_time, want.last,
                   got.kind, got.vertex, got.finish_time, got.last);
        mismatch_count_o++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_graph();
    end else begin
      if (result_valid_i) check_result(result_i);
      if (cfg_we_i) vcount_q = cfg_wdata_i;
      if (start_i && !busy_i) run_request(req_i);
    end
    outstanding_o = due_results.size();
  end

endmodule

// ===== sim/dfs_finish_time_walker_tb.sv =====
// ----------------------------------------------------------------------------
// dfs_finish_time_walker_tb: testbench of the depth-first finish-time walker
// Drives directed and random requests and vertex_count settings, with random
// idle bursts, and takes its verdict from the checker beside the block.
// ----------------------------------------------------------------------------
module dfs_finish_time_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  // Longest stretch without an accepted request or result before the run is
  // abandoned; the longest quiet spell between results, even in a full walk
  // over a full edge store, stays well below it.
  localparam int STALL_LIMIT = 4000;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       start;
  dfsw_pkg::req_t             req;
  logic                       busy;
  logic                       cfg_we;
  logic [dfsw_pkg::CNT_W-1:0] cfg_wdata;
  logic                       result_valid;
  dfsw_pkg::res_t             result;
  int                         mismatches;
  int                         outstanding;
  int                         stall_cycles = 0;

  // 4 ns clock: 2 ns high, 2 ns low.
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  dfs_finish_time_walker #(
    .VERTICES (32),
    .EDGES    (64)
  ) DUT (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .start_i        (start),
    .req_i          (req),
    .busy_o         (busy),
    .cfg_we_i       (cfg_we),
    .cfg_wdata_i    (cfg_wdata),
    .result_valid_o (result_valid),
    .result_o       (result)
  );

  dfs_finish_time_walker_checker walk_check (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .req_i            (req),
    .cfg_we_i         (cfg_we),
    .cfg_wdata_i      (cfg_wdata),
    .result_valid_i   (result_valid),
    .result_i         (result),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding)
  );

  // Watchdog: any accepted request or result counts as progress.
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || result_valid) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    wait (stall_cycles >= STALL_LIMIT);
    $display("FAIL dfs_finish_time_walker");
    $finish;
  end

  // Presents one request from a falling edge and holds it until the block
  // takes it. Returns at the next falling edge with start still high, so a
  // following request can go straight out without start dropping.
  task automatic issue(input logic [1:0] cmd, input int src, input int dst);
    dfsw_pkg::req_t r;
    r.cmd = cmd;
    r.src = dfsw_pkg::VTX_W'(src);
    r.dst = dfsw_pkg::VTX_W'(dst);
    start <= 1'b1;
    req   <= r;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  // Leaves the request side quiet for a number of cycles.
  task automatic idle_gap(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Stops sending, waits until every expected result has come back and the
  // block has settled, then writes vertex_count.
  task automatic set_vertex_count(input logic [dfsw_pkg::CNT_W-1:0] value);
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (6) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // Half of the vertices are drawn from a small cluster so that random edges
  // form deep chains and cycles rather than a sparse scatter.
  function automatic int random_vertex();
    if ($urandom_range(1) == 0) return int'($urandom_range(7));
    return int'($urandom_range(31));
  endfunction

  initial begin
    logic [dfsw_pkg::CNT_W-1:0] round_count [8];
    int                         round;
    int                         n;
    int                         pick;
    bit                         idling;

    start     = 1'b0;
    req       = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    rst_n     = 1'b0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed part. With no edges stored, a full walk at the reset count
    // finishes all 32 vertices alone, so the times run up to 63.
    issue(dfsw_pkg::CMD_WALK, 0, 0);
    issue(dfsw_pkg::CMD_WALK, 0, 0);        // everything visited: a done result only
    issue(dfsw_pkg::CMD_EXPLORE, 31, 0);    // start already visited
    issue(dfsw_pkg::CMD_CLEAR, 0, 0);
    issue(dfsw_pkg::CMD_EXPLORE, 31, 0);
    // A cycle, a self loop, a duplicate edge and a back edge into the start.
    issue(dfsw_pkg::CMD_ADD, 0, 1);
    issue(dfsw_pkg::CMD_ADD, 1, 2);
    issue(dfsw_pkg::CMD_ADD, 2, 0);
    issue(dfsw_pkg::CMD_ADD, 0, 31);
    issue(dfsw_pkg::CMD_ADD, 31, 31);
    issue(dfsw_pkg::CMD_ADD, 0, 1);
    issue(dfsw_pkg::CMD_ADD, 2, 3);
    issue(dfsw_pkg::CMD_ADD, 3, 0);
    issue(dfsw_pkg::CMD_EXPLORE, 0, 0);     // vertex 31 was already visited
    issue(dfsw_pkg::CMD_CLEAR, 0, 0);
    issue(dfsw_pkg::CMD_EXPLORE, 2, 0);
    issue(dfsw_pkg::CMD_WALK, 0, 0);
    issue(dfsw_pkg::CMD_CLEAR, 0, 0);
    // A zero count walks nothing; a count of one starts trees only at vertex 0;
    // a count above the vertex range acts as the full range.
    set_vertex_count(6'd0);
    issue(dfsw_pkg::CMD_WALK, 0, 0);
    set_vertex_count(6'd1);
    issue(dfsw_pkg::CMD_WALK, 0, 0);
    issue(dfsw_pkg::CMD_CLEAR, 0, 0);
    set_vertex_count(6'd63);
    issue(dfsw_pkg::CMD_WALK, 0, 0);
    issue(dfsw_pkg::CMD_CLEAR, 0, 0);

    // Random part: eight rounds, each under its own vertex_count. Adds take the
    // largest share, so the edge store fills and later adds are turned away;
    // frequent clears keep the explores and walks finding fresh vertices.
    round_count = '{6'd32, 6'd0, 6'd63, 6'd1, 6'($urandom_range(63)),
                    6'd31, 6'd33, 6'($urandom_range(2, 32))};
    for (round = 0; round < 8; round++) begin
      set_vertex_count(round_count[round]);
      // The last round runs without any idling at all.
      idling = (round < 7) && ($urandom_range(3) != 0);
      for (n = 0; n < 56; n++) begin
        pick = int'($urandom_range(99));
        if (pick < 40)
          issue(dfsw_pkg::CMD_ADD, random_vertex(), random_vertex());
        else if (pick < 70)
          issue(dfsw_pkg::CMD_EXPLORE, random_vertex(), random_vertex());
        else if (pick < 82)
          issue(dfsw_pkg::CMD_WALK, random_vertex(), random_vertex());
        else
          issue(dfsw_pkg::CMD_CLEAR, random_vertex(), random_vertex());
        if (idling && $urandom_range(3) == 0) idle_gap(int'($urandom_range(1, 11)));
      end
    end

    // Drain: every request has gone in; wait for the last results and keep
    // watching the block in case something unexpected follows.
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (20) @(negedge clk);

    if (mismatches == 0 && outstanding == 0) begin
      $display("PASS dfs_finish_time_walker");
    end else begin
      $display("FAIL dfs_finish_time_walker");
    end
    $finish;
  end

endmodule
